### rtl/udiv_128_by_64_core_assert.svh
// Assertion macros for the 128-by-64 divider.
// Used by udiv_128_by_64_core; no other dependencies.
`ifndef UDIV_128_BY_64_CORE_ASSERT_SVH
`define UDIV_128_BY_64_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UDIV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UDIV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/udiv_pkg.sv
// Types and constants shared by the 128-by-64 divider modules.
// No dependencies.
package udiv_pkg;

   localparam int WordWidth = 64;
   localparam int StepCount = WordWidth;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type dividend_high;
      word_type dividend_low;
      word_type divisor;
   } req_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     overflow;
   } rsp_type;

   // One pipeline stage: partial remainder, and a word that holds the dividend
   // bits still to shift in on top with the quotient bits growing below.
   typedef struct packed {
      word_type rem;
      word_type low_quot;
      word_type divisor;
      logic     overflow;
   } stage_type;

   localparam word_type AllOnes = {WordWidth{1'b1}};

endpackage

### rtl/udiv_step.sv
// One restoring-division stage: produces one quotient bit per item.
// Depends on udiv_pkg.
module udiv_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  udiv_pkg::stage_type  in_stage,
   output logic                 out_valid,
   output udiv_pkg::stage_type  out_stage
);

   logic                          valid_ff;
   udiv_pkg::stage_type           stage_ff;
   udiv_pkg::stage_type           stage_in;
   logic [udiv_pkg::WordWidth:0]  trial;
   logic [udiv_pkg::WordWidth:0]  diff;
   logic                          quot_bit;

   always_comb begin
      // shift the next dividend bit into the partial remainder
      trial    = {in_stage.rem, in_stage.low_quot[udiv_pkg::WordWidth-1]};
      diff     = trial - {1'b0, in_stage.divisor};
      quot_bit = (trial >= {1'b0, in_stage.divisor});
      stage_in = in_stage;
      stage_in.rem = quot_bit ? diff[udiv_pkg::WordWidth-1:0]
                              : trial[udiv_pkg::WordWidth-1:0];
      stage_in.low_quot = {in_stage.low_quot[udiv_pkg::WordWidth-2:0], quot_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

### rtl/udiv_128_by_64_core.sv
// Pipelined unsigned 128-by-64 divider: quotient, remainder, overflow flag.
// Path from req beat to rsp_valid: input register loaded at the beat, 64 subtract stages,
// output stage. Throughput: one beat per cycle unless rsp stalls; one 65-bit compare/subtract per stage.
// A stalled rsp holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (synchronous, active high) clears only the valid bits; payload is not reset.
// Depends on udiv_pkg, udiv_step and udiv_128_by_64_core_assert.svh.
`include "udiv_128_by_64_core_assert.svh"

module udiv_128_by_64_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  udiv_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output udiv_pkg::rsp_type  rsp_data
);

   logic                 enable;
   logic                 valid_pipe [0:udiv_pkg::StepCount];
   udiv_pkg::stage_type  stage_pipe [0:udiv_pkg::StepCount];

   logic                 in_valid_ff;
   udiv_pkg::stage_type  in_stage_ff;
   udiv_pkg::stage_type  in_stage_in;

   logic                 rsp_valid_ff;
   udiv_pkg::rsp_type    rsp_ff;
   udiv_pkg::rsp_type    rsp_in;

   // advance everything unless a finished beat is waiting at the output
   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   always_comb begin
      in_stage_in.rem      = req_data.dividend_high;
      in_stage_in.low_quot = req_data.dividend_low;
      in_stage_in.divisor  = req_data.divisor;
      // covers a zero divisor too
      in_stage_in.overflow = (req_data.dividend_high >= req_data.divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         in_stage_ff <= in_stage_in;
      end
   end

   assign valid_pipe[0] = in_valid_ff;
   assign stage_pipe[0] = in_stage_ff;

   for (genvar i = 0; i < udiv_pkg::StepCount; i++) begin : g_step
      udiv_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (valid_pipe[i]),
         .in_stage  (stage_pipe[i]),
         .out_valid (valid_pipe[i+1]),
         .out_stage (stage_pipe[i+1])
      );
   end

   always_comb begin
      if (stage_pipe[udiv_pkg::StepCount].overflow) begin
         rsp_in.quotient  = udiv_pkg::AllOnes;
         rsp_in.remainder = udiv_pkg::AllOnes;
         rsp_in.overflow  = 1'b1;
      end else begin
         rsp_in.quotient  = stage_pipe[udiv_pkg::StepCount].low_quot;
         rsp_in.remainder = stage_pipe[udiv_pkg::StepCount].rem;
         rsp_in.overflow  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= valid_pipe[udiv_pkg::StepCount];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `UDIV_ASSERT_NOW(a_stall_only_on_output, clock, reset, !req_ready, rsp_valid_ff && !rsp_ready, "pipeline stalled without a blocked output beat")
   `UDIV_ASSERT_NOW(a_first_rem_in_range, clock, reset, valid_pipe[0] && !stage_pipe[0].overflow, stage_pipe[0].rem < stage_pipe[0].divisor, "entry remainder not below divisor")
   `UDIV_ASSERT_NOW(a_last_rem_in_range, clock, reset, valid_pipe[udiv_pkg::StepCount] && !stage_pipe[udiv_pkg::StepCount].overflow, stage_pipe[udiv_pkg::StepCount].rem < stage_pipe[udiv_pkg::StepCount].divisor, "final remainder not below divisor")
   `UDIV_ASSERT_NEXT(a_stall_holds_pipe, clock, reset, !enable, $stable(valid_pipe[0]) && $stable(valid_pipe[udiv_pkg::StepCount]), "valid bits moved during a stall")

endmodule
